// File: rtl/jsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsc_pkg
// Shared constants, literal tables and helper functions for the streaming
// JSON syntax checker.
// ----------------------------------------------------------------------------
package jsc_pkg;

  // Default depth of the container stack.
  localparam int MAX_NEST_DEF = 32;

  // Bytes below this value are control characters and are illegal in strings.
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  // Input item kinds carried on the input side-band.
  localparam logic MODE_BYTE    = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  // Literal that is being matched.
  typedef enum logic [1:0] {
    LIT_NONE  = 2'd0,
    LIT_TRUE  = 2'd1,
    LIT_FALSE = 2'd2,
    LIT_NULL  = 2'd3
  } lit_kind_t;

  // Number of characters in a literal.
  function automatic logic [2:0] lit_len(lit_kind_t k);
    logic [2:0] len;
    case (k)
      LIT_TRUE:  len = 3'd4;
      LIT_FALSE: len = 3'd5;
      LIT_NULL:  len = 3'd4;
      default:   len = 3'd0;
    endcase
    return len;
  endfunction

  // Character at a given position of a literal; zero past its end.
  function automatic logic [7:0] lit_char(lit_kind_t k, logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      LIT_TRUE: begin
        case (idx)
          3'd0:    c = "t";
          3'd1:    c = "r";
          3'd2:    c = "u";
          3'd3:    c = "e";
          default: c = 8'h00;
        endcase
      end
      LIT_FALSE: begin
        case (idx)
          3'd0:    c = "f";
          3'd1:    c = "a";
          3'd2:    c = "l";
          3'd3:    c = "s";
          3'd4:    c = "e";
          default: c = 8'h00;
        endcase
      end
      LIT_NULL: begin
        case (idx)
          3'd0:    c = "n";
          3'd1:    c = "u";
          3'd2:    c = "l";
          3'd3:    c = "l";
          default: c = 8'h00;
        endcase
      end
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Whitespace as JSON defines it.
  function automatic logic is_space(logic [7:0] c);
    return (c == " ") || (c == 8'h0A) || (c == 8'h0D) || (c == 8'h09);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

endpackage

// File: rtl/json_syntax_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_syntax_checker
// Streaming JSON syntax checker: one text byte or restart command per item,
// one result per item with the accept flag, the value-complete flag and the
// current nesting depth.
// ----------------------------------------------------------------------------
// Stages: input register, then result register; an accepted item waits in the
// input register until the result register is free to take its result.
// Throughput: 1 item per cycle while the receiver does not stall; the parse
// state is updated once per item, with a re-check of a byte ending a number.
// Reset: synchronous, active low; the parser returns to the value-start phase
// with nothing open, both pipeline registers are emptied and no item is taken.
module json_syntax_checker
  import jsc_pkg::*;
#(
  parameter int MAX_NEST = MAX_NEST_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // Input channel
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] ch
  input  logic       in_tuser,   // [0] mode
  // Result channel
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] accepted, [1] complete, [7:2] nest_level
);

  localparam int CNT_W = $clog2(MAX_NEST + 1);
  localparam int STK_D = (MAX_NEST > 1) ? MAX_NEST : 2;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [4:0] {
    PH_VALUE_START = 5'd0,
    PH_KEY_OR_END  = 5'd1,
    PH_COLON       = 5'd2,
    PH_OBJ_SEP     = 5'd3,
    PH_ARR_VALUE   = 5'd4,
    PH_ARR_SEP     = 5'd5,
    PH_STRING      = 5'd6,
    PH_ESCAPE      = 5'd7,
    PH_HEX1        = 5'd8,
    PH_HEX2        = 5'd9,
    PH_HEX3        = 5'd10,
    PH_HEX4        = 5'd11,
    PH_NUM_INT     = 5'd12,
    PH_NUM_FRAC    = 5'd13,
    PH_NUM_EXP     = 5'd14,
    PH_LITERAL     = 5'd15,
    PH_DONE        = 5'd16
  } phase_t;

  // Parser state plus the side effects of one pass over a byte.
  typedef struct packed {
    phase_t    phase;
    cnt_t      cnt;
    logic      key;
    lit_kind_t lkind;
    logic [2:0] lidx;
    logic      push;
    logic      push_kind;
    logic      pop;
    logic      ok;
    logic      again;
  } pass_t;

  localparam cnt_t CNT_MAX = CNT_W'(MAX_NEST);

  // Phase after a value ends in the current container.
  function automatic phase_t after_value(cnt_t cnt, logic top0);
    phase_t ph;
    if (cnt == '0) begin
      ph = PH_DONE;
    end else if (top0) begin
      ph = PH_OBJ_SEP;
    end else begin
      ph = PH_ARR_SEP;
    end
    return ph;
  endfunction

  // Closing bracket: pop the stack and move to the outer container.
  function automatic pass_t do_close(pass_t s, logic top1);
    pass_t r;
    r = s;
    r.ok = 1'b1;
    if (s.cnt == '0) begin
      r.phase = PH_DONE;
    end else begin
      r.pop = 1'b1;
      r.cnt = CNT_W'(s.cnt - 1'b1);
      if (r.cnt == '0) begin
        r.phase = PH_DONE;
      end else if (top1) begin
        r.phase = PH_OBJ_SEP;
      end else begin
        r.phase = PH_ARR_SEP;
      end
    end
    return r;
  endfunction

  // Opening bracket: push unless the stack is full.
  function automatic pass_t do_open(pass_t s, logic is_obj);
    pass_t r;
    r = s;
    if (s.cnt < CNT_MAX) begin
      r.ok        = 1'b1;
      r.push      = 1'b1;
      r.push_kind = is_obj;
      r.cnt       = CNT_W'(s.cnt + 1'b1);
      r.phase     = is_obj ? PH_KEY_OR_END : PH_ARR_VALUE;
    end
    return r;
  endfunction

  // Start matching a literal; its first character is already seen.
  function automatic pass_t do_literal(pass_t s, lit_kind_t k);
    pass_t r;
    r = s;
    r.ok    = 1'b1;
    r.lkind = k;
    r.lidx  = 3'd1;
    r.phase = PH_LITERAL;
    return r;
  endfunction

  // One pass of the grammar over byte c. Rejected bytes leave the state
  // alone, except where the byte is handed on to the next pass.
  function automatic pass_t one_pass(pass_t s, logic [7:0] c, logic top0, logic top1);
    pass_t      r;
    logic [2:0] len;
    logic [2:0] idx_inc;
    r           = s;
    r.ok        = 1'b0;
    r.again     = 1'b0;
    r.push      = 1'b0;
    r.push_kind = 1'b0;
    r.pop       = 1'b0;
    len         = lit_len(s.lkind);
    idx_inc     = s.lidx + 3'd1;
    unique case (s.phase)
      PH_VALUE_START: begin
        if (is_space(c)) begin
          r.ok = 1'b1;
        end else if (c == "{") begin
          r = do_open(r, 1'b1);
        end else if (c == "[") begin
          r = do_open(r, 1'b0);
        end else if (c == "\"") begin
          r.ok    = 1'b1;
          r.phase = PH_STRING;
        end else if ((c == "-") || is_digit(c)) begin
          r.ok    = 1'b1;
          r.phase = PH_NUM_INT;
        end else if (c == "t") begin
          r = do_literal(r, LIT_TRUE);
        end else if (c == "f") begin
          r = do_literal(r, LIT_FALSE);
        end else if (c == "n") begin
          r = do_literal(r, LIT_NULL);
        end
      end
      PH_KEY_OR_END: begin
        if (is_space(c)) begin
          r.ok = 1'b1;
        end else if (c == "}") begin
          r = do_close(r, top1);
        end else if (c == "\"") begin
          r.ok    = 1'b1;
          r.key   = 1'b1;
          r.phase = PH_STRING;
        end
      end
      PH_COLON: begin
        if (is_space(c)) begin
          r.ok = 1'b1;
        end else if (c == ":") begin
          r.ok    = 1'b1;
          r.phase = PH_VALUE_START;
        end
      end
      PH_OBJ_SEP: begin
        if (is_space(c)) begin
          r.ok = 1'b1;
        end else if (c == ",") begin
          r.ok    = 1'b1;
          r.phase = PH_KEY_OR_END;
        end else if (c == "}") begin
          r = do_close(r, top1);
        end
      end
      PH_ARR_VALUE: begin
        if (is_space(c)) begin
          r.ok = 1'b1;
        end else if (c == "]") begin
          r = do_close(r, top1);
        end else begin
          // Any other byte is the start of an element.
          r.phase = PH_VALUE_START;
          r.again = 1'b1;
        end
      end
      PH_ARR_SEP: begin
        if (is_space(c)) begin
          r.ok = 1'b1;
        end else if (c == ",") begin
          r.ok    = 1'b1;
          r.phase = PH_ARR_VALUE;
        end else if (c == "]") begin
          r = do_close(r, top1);
        end
      end
      PH_STRING: begin
        if (c == "\"") begin
          r.ok = 1'b1;
          if ((s.cnt != '0) && top0 && s.key) begin
            r.key   = 1'b0;
            r.phase = PH_COLON;
          end else begin
            r.phase = after_value(s.cnt, top0);
          end
        end else if (c == "\\") begin
          r.ok    = 1'b1;
          r.phase = PH_ESCAPE;
        end else begin
          r.ok = (c >= CTRL_LIMIT);
        end
      end
      PH_ESCAPE: begin
        if ((c == "\"") || (c == "\\") || (c == "/") || (c == "b") ||
            (c == "f") || (c == "n") || (c == "r") || (c == "t")) begin
          r.ok    = 1'b1;
          r.phase = PH_STRING;
        end else if (c == "u") begin
          r.ok    = 1'b1;
          r.phase = PH_HEX1;
        end
      end
      PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
        if (is_hex(c)) begin
          r.ok = 1'b1;
          case (s.phase)
            PH_HEX1: r.phase = PH_HEX2;
            PH_HEX2: r.phase = PH_HEX3;
            PH_HEX3: r.phase = PH_HEX4;
            default: r.phase = PH_STRING;
          endcase
        end
      end
      PH_NUM_INT: begin
        if (is_digit(c)) begin
          r.ok = 1'b1;
        end else if (c == ".") begin
          r.ok    = 1'b1;
          r.phase = PH_NUM_FRAC;
        end else if ((c == "e") || (c == "E")) begin
          r.ok    = 1'b1;
          r.phase = PH_NUM_EXP;
        end else begin
          r.phase = after_value(s.cnt, top0);
          r.again = 1'b1;
        end
      end
      PH_NUM_FRAC: begin
        if (is_digit(c)) begin
          r.ok = 1'b1;
        end else if ((c == "e") || (c == "E")) begin
          r.ok    = 1'b1;
          r.phase = PH_NUM_EXP;
        end else begin
          r.phase = after_value(s.cnt, top0);
          r.again = 1'b1;
        end
      end
      PH_NUM_EXP: begin
        if ((c == "+") || (c == "-") || is_digit(c)) begin
          r.ok = 1'b1;
        end else begin
          r.phase = after_value(s.cnt, top0);
          r.again = 1'b1;
        end
      end
      PH_LITERAL: begin
        if ((s.lidx < len) && (c == lit_char(s.lkind, s.lidx))) begin
          r.ok   = 1'b1;
          r.lidx = idx_inc;
          if (idx_inc >= len) begin
            r.phase = after_value(s.cnt, top0);
          end
        end
      end
      PH_DONE: begin
        r.ok = is_space(c);
      end
      default: begin
        r.ok = 1'b0;
      end
    endcase
    return r;
  endfunction

  // Parser state
  phase_t            phase_r;
  cnt_t              cnt_r;
  logic              key_r;
  lit_kind_t         lkind_r;
  logic [2:0]        lidx_r;
  logic [STK_D-1:0]  kind_stk_r;   // bit 0 is the innermost container, 1 = object

  // Input register
  logic       s1_valid_r;
  logic       s1_mode_r;
  logic [7:0] s1_ch_r;

  // Result register
  logic       out_valid_r;
  logic [7:0] out_data_r;

  logic  advance;
  logic  upd;
  pass_t cur;
  pass_t pass1;
  pass_t pass2;
  pass_t fin;
  logic  res_ok;
  logic  res_done;
  cnt_t  res_cnt;

  // Handshake: the input stage moves on when the result register is free.
  // No item is taken while reset is held.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = rst_n && (!s1_valid_r || advance);
  assign upd       = s1_valid_r && advance;

  // Two passes cover the byte that is handed on from a number or an array slot.
  always_comb begin
    cur           = '0;
    cur.phase     = phase_r;
    cur.cnt       = cnt_r;
    cur.key       = key_r;
    cur.lkind     = lkind_r;
    cur.lidx      = lidx_r;
    pass1         = one_pass(cur, s1_ch_r, kind_stk_r[0], kind_stk_r[1]);
    pass2         = one_pass(pass1, s1_ch_r, kind_stk_r[0], kind_stk_r[1]);
    fin           = pass1.again ? pass2 : pass1;
    if (s1_mode_r == MODE_RESTART) begin
      res_ok   = 1'b1;
      res_done = 1'b0;
      res_cnt  = '0;
    end else begin
      res_ok   = fin.ok && !fin.again;
      res_done = (fin.phase == PH_DONE);
      res_cnt  = fin.cnt;
    end
  end

  // Control state and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_VALUE_START;
      cnt_r       <= '0;
      key_r       <= 1'b0;
      lkind_r     <= LIT_NONE;
      lidx_r      <= 3'd0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (upd) begin
        if (s1_mode_r == MODE_RESTART) begin
          phase_r <= PH_VALUE_START;
          cnt_r   <= '0;
          key_r   <= 1'b0;
          lkind_r <= LIT_NONE;
          lidx_r  <= 3'd0;
        end else begin
          phase_r <= fin.phase;
          cnt_r   <= fin.cnt;
          key_r   <= fin.key;
          lkind_r <= fin.lkind;
          lidx_r  <= fin.lidx;
        end
      end
    end
  end

  // Payload registers and the container stack, which needs no reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_mode_r <= in_tuser;
      s1_ch_r   <= in_tdata;
    end
    if (upd) begin
      out_data_r <= {6'(res_cnt), res_done, res_ok};
      if (s1_mode_r == MODE_BYTE) begin
        if (fin.push) begin
          kind_stk_r <= {kind_stk_r[STK_D-2:0], fin.push_kind};
        end else if (fin.pop) begin
          kind_stk_r <= {kind_stk_r[STK_D-1], kind_stk_r[STK_D-1:1]};
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The open count never passes the stack depth.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_MAX)
    else $error("open count above stack depth");

  // The done phase is only reached with no container open.
  a_done_flat: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE) |-> (cnt_r == '0))
    else $error("done phase with open containers");

  // A restart item always yields an accepted result at depth zero.
  a_restart_res: assert property (@(posedge clk) disable iff (!rst_n)
    (upd && (s1_mode_r == MODE_RESTART)) |=>
      (out_tvalid && out_tdata[0] && !out_tdata[1] && (out_tdata[7:2] == 6'd0)))
    else $error("restart result wrong");

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for json_syntax_checker. A queue of byte and restart
// items is streamed into the block while a local parser model predicts the
// accept flag, the complete flag and the nesting depth of every result. The
// stimulus mixes a few directed sequences with random JSON documents, deep
// nesting past the depth limit, corrupted and cut-off documents and noise,
// under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb
  import jsc_pkg::*;
;

  localparam int NEST         = MAX_NEST_DEF;
  localparam int N_TARGET     = 1250;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 10;
  localparam int REPORT_MAX   = 10;

  // Grammar position of the local parser model.
  typedef enum logic [4:0] {
    ST_VALUE, ST_KEY, ST_COLON, ST_OSEP, ST_AVAL, ST_ASEP, ST_STR, ST_ESC,
    ST_HEX1, ST_HEX2, ST_HEX3, ST_HEX4, ST_INT, ST_FRAC, ST_EXP, ST_LIT, ST_DONE
  } phase_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] ch;
  } item_t;

  typedef struct packed {
    logic       accepted;
    logic       complete;
    logic [5:0] level;
  } verdict_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;  // [7:0] ch
  logic       in_tuser   = 1'b0;   // [0] mode
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [0] accepted, [1] complete, [7:2] nest_level

  json_syntax_checker #(.MAX_NEST(NEST)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Stimulus, expectations and run statistics.
  item_t      feed_q[$];
  verdict_t   verdict_q[$];
  logic [7:0] doc[$];
  item_t      drv_item;
  verdict_t   want;
  int         n_items    = 0;
  int         taken      = 0;
  int         n_results  = 0;
  int         n_bad      = 0;
  int         n_restarts = 0;
  int         n_acc      = 0;
  int         n_done     = 0;
  int         deepest    = 0;
  int         cycles     = 0;
  bit         timed_out;

  // Parser model state.
  phase_t     ph;
  logic [5:0] depth;
  logic       kinds[NEST];
  logic       key_pending;
  lit_kind_t  lit_k;
  logic [2:0] lit_i;

  // Clock.
  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------
  function automatic bit ws_char(logic [7:0] c);
    return c == 8'h20 || c == 8'h0A || c == 8'h0D || c == 8'h09;
  endfunction

  function automatic bit dec_char(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit hex_char(logic [7:0] c);
    return dec_char(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic string word_of(lit_kind_t k);
    case (k)
      LIT_TRUE:  return "true";
      LIT_FALSE: return "false";
      LIT_NULL:  return "null";
      default:   return "";
    endcase
  endfunction

  function automatic bit in_object();
    return depth > 0 && depth <= NEST && kinds[depth - 1] == 1'b1;
  endfunction

  // After a value ends, go to the separator of the enclosing container.
  function automatic void settle_value();
    if (depth == 0) ph = ST_DONE;
    else ph = in_object() ? ST_OSEP : ST_ASEP;
  endfunction

  function automatic void pop_level();
    if (depth > 0) depth = depth - 6'd1;
    settle_value();
  endfunction

  function automatic bit push_level(logic obj);
    if (depth >= NEST) return 1'b0;
    kinds[depth] = obj;
    depth = depth + 6'd1;
    ph = obj ? ST_KEY : ST_AVAL;
    return 1'b1;
  endfunction

  function automatic bit begin_word(lit_kind_t k);
    lit_k = k;
    lit_i = 3'd1;
    ph = ST_LIT;
    return 1'b1;
  endfunction

  function automatic void clear_parser();
    ph = ST_VALUE;
    depth = '0;
    key_pending = 1'b0;
    lit_k = LIT_NONE;
    lit_i = '0;
  endfunction

  // One look at byte c; again is set when c must be looked at once more.
  function automatic bit scan_once(logic [7:0] c, output bit again);
    string w;
    again = 1'b0;
    case (ph)
      ST_VALUE: begin
        if (ws_char(c)) return 1'b1;
        if (c == "{") return push_level(1'b1);
        if (c == "[") return push_level(1'b0);
        if (c == "\"") begin
          ph = ST_STR;
          return 1'b1;
        end
        if (c == "-" || dec_char(c)) begin
          ph = ST_INT;
          return 1'b1;
        end
        if (c == "t") return begin_word(LIT_TRUE);
        if (c == "f") return begin_word(LIT_FALSE);
        if (c == "n") return begin_word(LIT_NULL);
        return 1'b0;
      end
      ST_KEY: begin
        if (ws_char(c)) return 1'b1;
        if (c == "}") begin
          pop_level();
          return 1'b1;
        end
        if (c == "\"") begin
          key_pending = 1'b1;
          ph = ST_STR;
          return 1'b1;
        end
        return 1'b0;
      end
      ST_COLON: begin
        if (ws_char(c)) return 1'b1;
        if (c == ":") begin
          ph = ST_VALUE;
          return 1'b1;
        end
        return 1'b0;
      end
      ST_OSEP: begin
        if (ws_char(c)) return 1'b1;
        if (c == ",") begin
          ph = ST_KEY;
          return 1'b1;
        end
        if (c == "}") begin
          pop_level();
          return 1'b1;
        end
        return 1'b0;
      end
      ST_AVAL: begin
        if (ws_char(c)) return 1'b1;
        if (c == "]") begin
          pop_level();
          return 1'b1;
        end
        // Anything else opens a value slot and is looked at again there.
        ph = ST_VALUE;
        again = 1'b1;
        return 1'b0;
      end
      ST_ASEP: begin
        if (ws_char(c)) return 1'b1;
        if (c == ",") begin
          ph = ST_AVAL;
          return 1'b1;
        end
        if (c == "]") begin
          pop_level();
          return 1'b1;
        end
        return 1'b0;
      end
      ST_STR: begin
        if (c == "\"") begin
          if (in_object() && key_pending) begin
            key_pending = 1'b0;
            ph = ST_COLON;
          end else begin
            settle_value();
          end
          return 1'b1;
        end
        if (c == "\\") begin
          ph = ST_ESC;
          return 1'b1;
        end
        return c >= CTRL_LIMIT;
      end
      ST_ESC: begin
        if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
            c == "n" || c == "r" || c == "t") begin
          ph = ST_STR;
          return 1'b1;
        end
        if (c == "u") begin
          ph = ST_HEX1;
          return 1'b1;
        end
        return 1'b0;
      end
      ST_HEX1, ST_HEX2, ST_HEX3, ST_HEX4: begin
        if (!hex_char(c)) return 1'b0;
        case (ph)
          ST_HEX1: ph = ST_HEX2;
          ST_HEX2: ph = ST_HEX3;
          ST_HEX3: ph = ST_HEX4;
          default: ph = ST_STR;
        endcase
        return 1'b1;
      end
      ST_INT, ST_FRAC, ST_EXP: begin
        if (dec_char(c)) return 1'b1;
        if (ph == ST_INT && c == ".") begin
          ph = ST_FRAC;
          return 1'b1;
        end
        if (ph != ST_EXP && (c == "e" || c == "E")) begin
          ph = ST_EXP;
          return 1'b1;
        end
        if (ph == ST_EXP && (c == "+" || c == "-")) return 1'b1;
        // The byte ends the number and is looked at again in the outer context.
        settle_value();
        again = 1'b1;
        return 1'b0;
      end
      ST_LIT: begin
        w = word_of(lit_k);
        if (lit_i < w.len() && c == w[lit_i]) begin
          lit_i = lit_i + 3'd1;
          if (lit_i >= w.len()) settle_value();
          return 1'b1;
        end
        return 1'b0;
      end
      ST_DONE: return ws_char(c);
      default: return 1'b0;
    endcase
  endfunction

  // Applies one input item to the model and returns the result it gives.
  function automatic verdict_t apply_item(item_t it);
    bit ok;
    bit again;
    verdict_t v;
    ok = 1'b1;
    again = 1'b0;
    if (it.mode == MODE_RESTART) begin
      clear_parser();
    end else begin
      for (int pass = 0; pass < 2; pass++) begin
        ok = scan_once(it.ch, again);
        if (!again) break;
      end
      if (again) ok = 1'b0;
    end
    v.accepted = ok;
    v.complete = (ph == ST_DONE);
    v.level = depth;
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus generation
  // --------------------------------------------------------------------------
  function automatic void put_doc(logic [7:0] c);
    doc.insert(doc.size(), c);
  endfunction

  function automatic void add_byte(logic [7:0] c);
    feed_q.insert(feed_q.size(), item_t'{mode: MODE_BYTE, ch: c});
  endfunction

  function automatic void add_restart();
    logic [7:0] junk;
    junk = 8'($urandom_range(255));
    feed_q.insert(feed_q.size(), item_t'{mode: MODE_RESTART, ch: junk});
    n_restarts++;
  endfunction

  function automatic void add_text(string s);
    foreach (s[i]) add_byte(s[i]);
  endfunction

  function automatic void emit_text(string s);
    foreach (s[i]) put_doc(s[i]);
  endfunction

  function automatic void gen_ws();
    string spaces;
    int n;
    spaces = " \n\r\t";
    n = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) put_doc(spaces[$urandom_range(3)]);
  endfunction

  function automatic void gen_string();
    string escs;
    string hexs;
    logic [7:0] c;
    int r;
    escs = "\"\\/bfnrt";
    hexs = "0123456789abcdefABCDEF";
    put_doc("\"");
    repeat ($urandom_range(0, 5)) begin
      r = $urandom_range(9);
      if (r == 0) begin
        put_doc("\\");
        put_doc(escs[$urandom_range(7)]);
      end else if (r == 1) begin
        emit_text("\\u");
        repeat (4) put_doc(hexs[$urandom_range(21)]);
      end else begin
        c = 8'($urandom_range(8'h20, 8'hFF));
        if (c == "\"" || c == "\\") c = "a";
        put_doc(c);
      end
    end
    put_doc("\"");
  endfunction

  function automatic void gen_digits();
    repeat ($urandom_range(1, 3)) put_doc(8'($urandom_range("0", "9")));
  endfunction

  function automatic void gen_number();
    if ($urandom_range(2) == 0) put_doc("-");
    gen_digits();
    if ($urandom_range(2) == 0) begin
      put_doc(".");
      gen_digits();
    end
    if ($urandom_range(2) == 0) begin
      put_doc($urandom_range(1) ? "e" : "E");
      case ($urandom_range(2))
        0: put_doc("+");
        1: put_doc("-");
        default: ;
      endcase
      gen_digits();
    end
  endfunction

  // One random well-formed value; containers only near the top.
  function automatic void gen_value(int lvl);
    int r;
    int n;
    r = (lvl >= 3) ? $urandom_range(4, 9) : $urandom_range(9);
    case (r)
      0, 1: begin
        put_doc("{");
        gen_ws();
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) put_doc(",");
          gen_ws();
          gen_string();
          gen_ws();
          put_doc(":");
          gen_ws();
          gen_value(lvl + 1);
          gen_ws();
        end
        put_doc("}");
      end
      2, 3: begin
        put_doc("[");
        gen_ws();
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) put_doc(",");
          gen_ws();
          gen_value(lvl + 1);
          gen_ws();
        end
        put_doc("]");
      end
      4, 5:    gen_string();
      6, 7, 9: gen_number();
      default: begin
        case ($urandom_range(2))
          0: emit_text("true");
          1: emit_text("false");
          default: emit_text("null");
        endcase
      end
    endcase
  endfunction

  // Nesting around the depth limit; openings past the limit are arrays.
  function automatic void gen_deep();
    logic closers[$];
    int n;
    n = $urandom_range(28, 34);
    for (int i = 0; i < n; i++) begin
      if (i < NEST && $urandom_range(3) == 0) begin
        emit_text("{\"a\":");
        closers.push_front(1'b1);
      end else begin
        put_doc("[");
        if (i < NEST) closers.push_front(1'b0);
      end
    end
    gen_value(9);
    foreach (closers[i]) put_doc(closers[i] ? "}" : "]");
  endfunction

  function automatic void build_stimulus();
    int r;
    int pos;
    // Directed: byte extremes, object with an exponent number ended by the
    // closing brace, whitespace and junk after the end, array holding an
    // escaped string with a unicode escape and a literal cut short by ']'.
    add_byte(8'h00);
    add_byte(8'hFF);
    add_text("{\"k\":-1e+5}");
    add_text(" x");
    add_restart();
    add_text("[\"\\uA0f9\",n]");
    // Random documents, mostly well formed.
    while (feed_q.size() < N_TARGET) begin
      doc.delete();
      r = $urandom_range(99);
      gen_ws();
      if (r < 8) gen_deep();
      else gen_value(0);
      if (r >= 70 && r < 85) begin
        pos = $urandom_range(doc.size() - 1);
        doc[pos] = 8'($urandom_range(255));
      end else if (r >= 85 && r < 92) begin
        pos = $urandom_range(doc.size() - 1);
        while (doc.size() > pos) void'(doc.pop_back());
      end else if (r >= 92) begin
        doc.delete();
        repeat ($urandom_range(1, 6)) put_doc(8'($urandom_range(255)));
      end
      gen_ws();
      if ($urandom_range(9) != 0) add_restart();
      foreach (doc[i]) add_byte(doc[i]);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Idling: no gaps, sender gaps, receiver stalls, then both.
  // --------------------------------------------------------------------------
  int idle_sel;
  int send_idle_pct;
  int stall_pct;

  assign idle_sel = (n_items == 0) ? 0 : (taken * 4) / n_items;

  always_comb begin
    case (idle_sel)
      0: begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      1: begin
        send_idle_pct = 53;
        stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        stall_pct = 53;
      end
      default: begin
        send_idle_pct = 30;
        stall_pct = 30;
      end
    endcase
  end

  // Driver: a new item goes out once the current one has been taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (feed_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_item = feed_q.pop_front();
        in_tvalid <= 1'b1;
        in_tuser <= drv_item.mode;
        in_tdata <= drv_item.ch;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver backpressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitor: checks each result against the oldest prediction, then predicts
  // the result of any item taken at this edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        n_results++;
        if (verdict_q.size() == 0) begin
          n_bad++;
          if (n_bad <= REPORT_MAX)
            $display("result %0d: no prediction pending, got %h", n_results, out_tdata);
        end else begin
          want = verdict_q.pop_front();
          if (out_tdata[0] !== want.accepted || out_tdata[1] !== want.complete ||
              out_tdata[7:2] !== want.level) begin
            n_bad++;
            if (n_bad <= REPORT_MAX)
              $display("result %0d: accepted %b/%b complete %b/%b level %0d/%0d %s",
                       n_results, want.accepted, out_tdata[0], want.complete,
                       out_tdata[1], want.level, out_tdata[7:2], "(expected/actual)");
          end
          if (want.accepted) n_acc++;
          if (want.complete) n_done++;
          if (want.level > deepest) deepest = want.level;
        end
      end
      if (in_tvalid && in_tready) begin
        verdict_q.insert(verdict_q.size(), apply_item(item_t'{mode: in_tuser, ch: in_tdata}));
        taken++;
      end
    end
  end

  // Sequence: build stimulus, release reset, wait for the drain, report.
  initial begin
    clear_parser();
    foreach (kinds[i]) kinds[i] = 1'b0;
    build_stimulus();
    n_items = feed_q.size();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (cycles < CYCLE_LIMIT && (taken < n_items || verdict_q.size() > 0))
      @(negedge clk);
    timed_out = (cycles >= CYCLE_LIMIT);
    if (!timed_out) repeat (DRAIN_CYCLES) @(negedge clk);
    if (timed_out) begin
      $display("timeout after %0d cycles, %0d of %0d items taken", cycles, taken, n_items);
      $display("end of test: mismatches");
    end else begin
      $display("%0d items (%0d restarts) gave %0d results: %0d accepted, %0d complete,",
               n_items, n_restarts, n_results, n_acc, n_done);
      $display("deepest nesting %0d, %0d mismatches", deepest, n_bad);
      if (n_bad == 0 && verdict_q.size() == 0) begin
        $display("end of test: clean");
      end else begin
        $display("end of test: mismatches");
      end
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/jsc_pkg.sv
rtl/json_syntax_checker.sv
tb/sv/tb.sv
